/* hdl/pcma_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pcma_pkg;

  // Default sizes of the block.
  localparam int unsigned ADC_BITS_DEF     = 12;
  localparam int unsigned WINDOW_DEPTH_DEF = 20;

  // Fixed register widths.
  localparam int unsigned APC_W      = 16;
  localparam int unsigned GAIN_W     = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // Register reset values.
  localparam int unsigned MID_RESET  = 2048;
  localparam int unsigned APC_RESET  = 754;
  localparam int unsigned GAIN_RESET = 20;

  // Sizes of the serial arithmetic unit at the default configuration.
  localparam int unsigned SUM_W_DEF   = 18;
  localparam int unsigned AVG_W_DEF   = 29;
  localparam int unsigned DIVISOR_DEF = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIDPOINT = 2'd0,
    CFG_APC      = 2'd1,
    CFG_GAIN     = 2'd2
  } cfg_reg_e;

endpackage

`default_nettype wire

/* hdl/phase_current_moving_average.sv */
// An accepted request passes through S_READ, S_UPD, S_CALC and S_DONE before its result
// reaches the output register. A new request is taken only after the last one has left
// S_DONE, as the bit-serial multiply, constant divide and gain multiply in the pcma_serial
// unit work on one request at a time.
// Reset (rst_ni, asynchronous, active low) clears control, the ring valid bits, the
// window sum and write index, and loads the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module phase_current_moving_average #(
  parameter int unsigned WINDOW_DEPTH = pcma_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned ADC_BITS     = pcma_pkg::ADC_BITS_DEF
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  // Configuration write port.
  input  logic                                                 cfg_we_i,
  input  logic [pcma_pkg::CFG_IDX_W-1:0]                       cfg_idx_i,
  input  logic [pcma_pkg::CFG_DATA_W-1:0]                      cfg_wdata_i,
  // Sample requests.
  input  logic                                                 in_valid_i,
  output logic                                                 in_ready_o,
  input  logic [ADC_BITS-1:0]                                  phase_b_sample_i,
  input  logic [ADC_BITS-1:0]                                  phase_c_sample_i,
  // Results.
  output logic                                                 out_valid_o,
  input  logic                                                 out_ready_i,
  output logic [ADC_BITS+1:0]                                  weighted_current_o,
  output logic [ADC_BITS+pcma_pkg::APC_W:0]                    avg_current_q16_o,
  output logic [ADC_BITS+pcma_pkg::APC_W+pcma_pkg::GAIN_W:0]   power_q16_o
);

  localparam int unsigned APC_W     = pcma_pkg::APC_W;
  localparam int unsigned GAIN_W    = pcma_pkg::GAIN_W;
  localparam int unsigned WGT_W     = ADC_BITS + 2;
  localparam int unsigned WGT_LIMIT = 5 << (ADC_BITS - 1);
  localparam int unsigned SUM_MAX   = WINDOW_DEPTH * WGT_LIMIT;
  localparam int unsigned SUM_W     = $clog2(SUM_MAX + 1);
  localparam int unsigned AVG_W     = ADC_BITS + APC_W + 1;
  localparam int unsigned PWR_W     = AVG_W + GAIN_W;
  localparam int unsigned IDX_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned DIVISOR   = 2 * WINDOW_DEPTH;

  // Sequencer: a request and its old ring entry are registered in S_IDLE, S_READ waits, the
  // sum and ring are updated and the serial unit started in S_UPD, S_CALC waits for the
  // serial unit and S_DONE hands the result to the output register.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_UPD  = 5'b00100,
    S_CALC = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [ADC_BITS-1:0] mid_q;
  logic [APC_W-1:0]    apc_q;
  logic [GAIN_W-1:0]   gain_q;

  // Ring of recent weighted values, kept as a memory. Each entry has a valid bit so that
  // an entry not yet written since reset reads as zero.
  logic [WGT_W-1:0]        ring_q [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] vld_q;
  logic [WGT_W-1:0]        old_raw_q;
  logic                    old_vld_q;
  logic [WGT_W-1:0]        old_val;

  logic [IDX_W-1:0] widx_q, widx_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [WGT_W-1:0] weighted_q;

  // Weighted current datapath.
  logic [ADC_BITS-1:0] diff_b, diff_c;
  logic [ADC_BITS+2:0] wgt_raw;
  logic [WGT_W-1:0]    wgt_sat;

  // Output register.
  logic             out_valid_q, out_valid_d;
  logic [WGT_W-1:0] out_wgt_q;
  logic [AVG_W-1:0] out_avg_q;
  logic [PWR_W-1:0] out_pwr_q;

  logic             in_acc;
  logic             load;
  logic             arith_done;
  logic [AVG_W-1:0] arith_avg;
  logic [PWR_W-1:0] arith_pwr;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load       = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Configuration writes. Indexes beyond the register list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q  <= ADC_BITS'(pcma_pkg::MID_RESET);
      apc_q  <= APC_W'(pcma_pkg::APC_RESET);
      gain_q <= GAIN_W'(pcma_pkg::GAIN_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pcma_pkg::CFG_MIDPOINT: mid_q  <= cfg_wdata_i[ADC_BITS-1:0];
        pcma_pkg::CFG_APC:      apc_q  <= cfg_wdata_i[APC_W-1:0];
        pcma_pkg::CFG_GAIN:     gain_q <= cfg_wdata_i[GAIN_W-1:0];
        default: begin
          mid_q <= mid_q;
        end
      endcase
    end
  end

  // The weighted value is twice the phase B magnitude plus three times the phase C
  // magnitude, in half counts. It saturates at the full-scale limit before it enters the
  // ring, so the window sum can never overflow.
  always_comb begin
    diff_b  = (phase_b_sample_i >= mid_q) ? (phase_b_sample_i - mid_q)
                                          : (mid_q - phase_b_sample_i);
    diff_c  = (phase_c_sample_i >= mid_q) ? (phase_c_sample_i - mid_q)
                                          : (mid_q - phase_c_sample_i);
    wgt_raw = {2'b00, diff_b, 1'b0} + {2'b00, diff_c, 1'b0} + {3'b000, diff_c};
    wgt_sat = (wgt_raw > (ADC_BITS+3)'(WGT_LIMIT)) ? WGT_W'(WGT_LIMIT)
                                                   : wgt_raw[WGT_W-1:0];
  end

  // The entry being replaced counts as zero until it has been written once.
  assign old_val = old_vld_q ? old_raw_q : '0;

  always_comb begin
    sum_d  = sum_q + SUM_W'(weighted_q) - SUM_W'(old_val);
    widx_d = (widx_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : (widx_q + 1'b1);
  end

  // Ring memory: read at request time with registered data, written in S_UPD.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      old_raw_q  <= ring_q[widx_q];
      old_vld_q  <= vld_q[widx_q];
      weighted_q <= wgt_sat;
    end
    if (state_q == S_UPD) begin
      ring_q[widx_q] <= weighted_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      widx_q <= '0;
      sum_q  <= '0;
    end else if (state_q == S_UPD) begin
      vld_q[widx_q] <= 1'b1;
      widx_q        <= widx_d;
      sum_q         <= sum_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        state_d = S_CALC;
      end
      S_CALC: begin
        if (arith_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The serial unit forms sum * amps_per_count, divides it by twice the window depth
  // and multiplies the truncated average by the gain. It takes the new sum directly so
  // that it can start in the same cycle as the sum update.
  pcma_serial #(
    .SUM_W   (SUM_W),
    .AVG_W   (AVG_W),
    .DIVISOR (DIVISOR)
  ) u_serial (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_UPD),
    .sum_i   (sum_d),
    .apc_i   (apc_q),
    .gain_i  (gain_q),
    .done_o  (arith_done),
    .avg_o   (arith_avg),
    .power_o (arith_pwr)
  );

  // Output register. It holds a finished result while the next request is worked on.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_wgt_q <= weighted_q;
      out_avg_q <= arith_avg;
      out_pwr_q <= arith_pwr;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign weighted_current_o = out_wgt_q;
  assign avg_current_q16_o  = out_avg_q;
  assign power_q16_o        = out_pwr_q;

`ifndef SYNTH
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= SUM_W'(SUM_MAX))
    else $error("window sum exceeds its bound");

  a_widx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    widx_q <= IDX_W'(WINDOW_DEPTH - 1))
    else $error("write index beyond the ring");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("result loaded but not presented");
`endif

endmodule

`default_nettype wire

/* hdl/pcma_serial.sv */
`timescale 1ns / 1ps
`default_nettype none

module pcma_serial #(
  parameter int unsigned SUM_W   = pcma_pkg::SUM_W_DEF,
  parameter int unsigned AVG_W   = pcma_pkg::AVG_W_DEF,
  parameter int unsigned DIVISOR = pcma_pkg::DIVISOR_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [SUM_W-1:0]                       sum_i,
  input  logic [pcma_pkg::APC_W-1:0]             apc_i,
  input  logic [pcma_pkg::GAIN_W-1:0]            gain_i,
  output logic                                   done_o,
  output logic [AVG_W-1:0]                       avg_o,
  output logic [AVG_W+pcma_pkg::GAIN_W-1:0]      power_o
);

  localparam int unsigned APC_W  = pcma_pkg::APC_W;
  localparam int unsigned GAIN_W = pcma_pkg::GAIN_W;
  localparam int unsigned PROD_W = SUM_W + APC_W;
  localparam int unsigned PWR_W  = AVG_W + GAIN_W;
  localparam int unsigned RW     = $clog2(DIVISOR);
  localparam int unsigned CNT_W  = $clog2(PROD_W);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_PWR  = 4'b1000
  } arith_state_e;

  arith_state_e state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PROD_W-1:0] p_q;
  logic [SUM_W-1:0]  m_q;
  logic [RW-1:0]     rem_q;
  logic [PWR_W-1:0]  x_q;

  logic [SUM_W:0]    mul_add;
  logic [RW:0]       trial;
  logic              ge;
  logic [RW:0]       rem_sub;
  logic [AVG_W:0]    pwr_add;

  // Multiply step: shift-add, one multiplier bit per cycle from the LSB.
  // Divide step: restoring division by a constant, one quotient bit per cycle.
  always_comb begin
    mul_add = {1'b0, p_q[PROD_W-1:APC_W]} + (p_q[0] ? {1'b0, m_q} : '0);
    trial   = {rem_q, p_q[PROD_W-1]};
    ge      = (trial >= (RW+1)'(DIVISOR));
    rem_sub = ge ? (trial - (RW+1)'(DIVISOR)) : trial;
    pwr_add = {1'b0, x_q[PWR_W-1:GAIN_W]} + (x_q[0] ? {1'b0, p_q[AVG_W-1:0]} : '0);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      A_IDLE: begin
        if (start_i) begin
          state_d = A_MUL;
          cnt_d   = CNT_W'(APC_W - 1);
        end
      end
      A_MUL: begin
        if (cnt_q == '0) begin
          state_d = A_DIV;
          cnt_d   = CNT_W'(PROD_W - 1);
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      A_DIV: begin
        if (cnt_q == '0) begin
          state_d = A_PWR;
          cnt_d   = CNT_W'(GAIN_W - 1);
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      A_PWR: begin
        if (cnt_q == '0) begin
          state_d = A_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      A_IDLE: begin
        if (start_i) begin
          p_q   <= {{SUM_W{1'b0}}, apc_i};
          m_q   <= sum_i;
          rem_q <= '0;
          x_q   <= {{AVG_W{1'b0}}, gain_i};
        end
      end
      A_MUL: begin
        p_q <= {mul_add, p_q[APC_W-1:1]};
      end
      A_DIV: begin
        p_q   <= {p_q[PROD_W-2:0], ge};
        rem_q <= rem_sub[RW-1:0];
      end
      A_PWR: begin
        x_q <= {pwr_add, x_q[GAIN_W-1:1]};
      end
      default: begin
        p_q <= p_q;
      end
    endcase
  end

  assign done_o  = (state_q == A_PWR) && (cnt_q == '0);
  assign avg_o   = p_q[AVG_W-1:0];
  assign power_o = x_q;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == A_IDLE)
    else $error("serial unit started while busy");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == A_DIV |-> {1'b0, rem_q} < (RW+1)'(DIVISOR))
    else $error("division remainder out of range");

  a_quot_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == A_PWR |-> p_q[PROD_W-1:AVG_W] == '0)
    else $error("average overflows its width");
`endif

endmodule

`default_nettype wire

/* test/phase_current_moving_average_tb.sv */
`timescale 1ns / 1ps

module phase_current_moving_average_tb;
  import pcma_pkg::*;

  localparam int unsigned ADC_W      = ADC_BITS_DEF;
  localparam int unsigned WIN_DEPTH  = WINDOW_DEPTH_DEF;
  localparam int unsigned SAMPLE_MAX = (1 << ADC_W) - 1;
  // The weighted value clips at five half-scale steps before it enters the ring.
  localparam int unsigned WEIGHT_MAX = 5 << (ADC_W - 1);
  // Cycles from an accepted request to its result.
  localparam int unsigned LATENCY    = APC_W + SUM_W_DEF + 16 + GAIN_W + 3;
  // Register index that lies past the implemented registers; writes to it are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    logic [ADC_W-1:0] phase_b;
    logic [ADC_W-1:0] phase_c;
  } sample_pair_t;

  typedef struct packed {
    logic [ADC_W+1:0]              weighted;
    logic [ADC_W+APC_W:0]          avg;
    logic [ADC_W+APC_W+GAIN_W:0]   power;
  } current_result_t;

  // All block inputs start at known values so nothing is undriven before reset ends.
  logic                          clk_i              = 1'b0;
  logic                          rst_ni             = 1'b0;
  logic                          cfg_we_i           = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_idx_i          = '0;
  logic [CFG_DATA_W-1:0]         cfg_wdata_i        = '0;
  logic                          in_valid_i         = 1'b0;
  logic                          in_ready_o;
  logic [ADC_W-1:0]              phase_b_sample_i   = '0;
  logic [ADC_W-1:0]              phase_c_sample_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i        = 1'b0;
  logic [ADC_W+1:0]              weighted_current_o;
  logic [ADC_W+APC_W:0]          avg_current_q16_o;
  logic [ADC_W+APC_W+GAIN_W:0]   power_q16_o;

  // Our own copy of the register file, kept in step with every write we issue.
  logic [ADC_W-1:0]  midpoint_cfg = ADC_W'(MID_RESET);
  logic [APC_W-1:0]  apc_cfg      = APC_W'(APC_RESET);
  logic [GAIN_W-1:0] gain_cfg     = GAIN_W'(GAIN_RESET);

  // Our own copy of the averaging window; it starts cleared, as the block does at reset.
  int unsigned window_ring [WIN_DEPTH];
  int unsigned window_total = 0;
  int unsigned ring_slot    = 0;

  sample_pair_t    sample_backlog [$];
  current_result_t expected_currents [$];

  // The driver owns sample_held; it mirrors in_valid_i but is updated with blocking
  // assignments, so the stimulus process can see whether a request is still on the bus
  // without racing the driver's nonblocking update.
  bit           sample_held = 1'b0;
  sample_pair_t staged;
  int unsigned  send_pause  = 0;
  int unsigned  send_calm   = 0;
  int unsigned  recv_stall  = 0;
  int unsigned  recv_calm   = 0;
  int unsigned  mismatch_count = 0;
  current_result_t observed;
  current_result_t wanted;

  initial begin
    foreach (window_ring[i]) window_ring[i] = 0;
  end

  // Works out the three result fields for one accepted request and moves the window on.
  function automatic current_result_t predict_currents(logic [ADC_W-1:0] b_sample,
                                                       logic [ADC_W-1:0] c_sample);
    int unsigned       dev_b;
    int unsigned       dev_c;
    int unsigned       weighted;
    longint unsigned   avg;
    longint unsigned   power;
    current_result_t   res;
    dev_b = (midpoint_cfg > b_sample) ? 32'(midpoint_cfg - b_sample)
                                      : 32'(b_sample - midpoint_cfg);
    dev_c = (midpoint_cfg > c_sample) ? 32'(midpoint_cfg - c_sample)
                                      : 32'(c_sample - midpoint_cfg);
    weighted = 2 * dev_b + 3 * dev_c;
    // An off-centre midpoint can push the weighted value past the clip level.
    if (weighted > WEIGHT_MAX) weighted = WEIGHT_MAX;
    window_total = window_total + weighted - window_ring[ring_slot];
    window_ring[ring_slot] = weighted;
    ring_slot = (ring_slot == WIN_DEPTH - 1) ? 0 : ring_slot + 1;
    // The divisor is fixed at twice the depth, even while the window is still filling,
    // and the quotient truncates; power is formed from the truncated average.
    avg   = (longint'(window_total) * longint'(apc_cfg)) / (2 * WIN_DEPTH);
    power = avg * longint'(gain_cfg);
    res.weighted = weighted[ADC_W+1:0];
    res.avg      = avg[ADC_W+APC_W:0];
    res.power    = power[ADC_W+APC_W+GAIN_W:0];
    return res;
  endfunction

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned draw_pause();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    else if (roll < 85) return $urandom_range(1, 3);
    else if (roll < 96) return $urandom_range(4, 20);
    else return $urandom_range(40, 150);
  endfunction

  // Samples are a mix of values near the midpoint, rail values and anything at all.
  function automatic logic [ADC_W-1:0] draw_sample();
    int pos;
    case ($urandom_range(0, 3))
      0: begin
        pos = int'(midpoint_cfg) + int'($urandom_range(0, 160)) - 80;
        if (pos < 0) pos = 0;
        if (pos > int'(SAMPLE_MAX)) pos = int'(SAMPLE_MAX);
        return pos[ADC_W-1:0];
      end
      1: begin
        return ($urandom_range(0, 1) != 0) ? '1 : '0;
      end
      default: begin
        return ADC_W'($urandom_range(0, SAMPLE_MAX));
      end
    endcase
  endfunction

  phase_current_moving_average dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .phase_b_sample_i   (phase_b_sample_i),
    .phase_c_sample_i   (phase_c_sample_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .weighted_current_o (weighted_current_o),
    .avg_current_q16_o  (avg_current_q16_o),
    .power_q16_o        (power_q16_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Request driver. A request is held with its payload steady until it is taken; the
  // prediction is made at the very edge where the block accepts it. After each request a
  // random gap may follow, except during calm stretches in which requests go back to back.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_currents.push_back(predict_currents(phase_b_sample_i, phase_c_sample_i));
        sample_held = 1'b0;
        if (send_calm > 0) begin
          send_calm--;
          send_pause = 0;
        end else begin
          send_pause = draw_pause();
          if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(10, 40);
        end
      end
      if (!sample_held) begin
        if (send_pause > 0) begin
          send_pause--;
        end else if (sample_backlog.size() != 0) begin
          staged = sample_backlog.pop_front();
          phase_b_sample_i <= staged.phase_b;
          phase_c_sample_i <= staged.phase_c;
          sample_held = 1'b1;
        end
      end
      in_valid_i <= sample_held;
    end
  end

  // Result monitor. Every result taken is checked against the oldest prediction. Ready
  // drops at random, with occasional long stalls and calm stretches where it stays high.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_currents.size() == 0) begin
          $error("result with no request outstanding: weighted_current %0d", weighted_current_o);
          mismatch_count++;
        end else begin
          wanted = expected_currents.pop_front();
          observed.weighted = weighted_current_o;
          observed.avg      = avg_current_q16_o;
          observed.power    = power_q16_o;
          if (observed.weighted !== wanted.weighted) begin
            $error("weighted_current: expected %0d, got %0d", wanted.weighted, observed.weighted);
            mismatch_count++;
          end
          if (observed.avg !== wanted.avg) begin
            $error("avg_current_q16: expected %0d, got %0d", wanted.avg, observed.avg);
            mismatch_count++;
          end
          if (observed.power !== wanted.power) begin
            $error("power_q16: expected %0d, got %0d", wanted.power, observed.power);
            mismatch_count++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (recv_calm > 0) begin
          recv_calm--;
        end else if ($urandom_range(0, 7) == 0) begin
          recv_stall = draw_pause();
          if ($urandom_range(0, 9) == 0) recv_calm = $urandom_range(50, 300);
        end
      end
    end
  end

  // One register write, lasting a single cycle of write enable. Our copy of the register
  // takes only the bits the register holds; the spare index changes nothing.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_MIDPOINT: midpoint_cfg = data[ADC_W-1:0];
      CFG_APC:      apc_cfg      = data[APC_W-1:0];
      CFG_GAIN:     gain_cfg     = data[GAIN_W-1:0];
      default:      ;
    endcase
  endtask

  // Upper data bits beyond a register's width are filled at random; the block drops them.
  task automatic set_registers(input int unsigned mid, input int unsigned apc,
                               input int unsigned gain);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom_range(0, 65535));
    data[ADC_W-1:0] = ADC_W'(mid);
    write_reg(CFG_MIDPOINT, data);
    data = CFG_DATA_W'(apc);
    write_reg(CFG_APC, data);
    data = CFG_DATA_W'($urandom_range(0, 65535));
    data[GAIN_W-1:0] = GAIN_W'(gain);
    write_reg(CFG_GAIN, data);
  endtask

  task automatic queue_pair(input int unsigned b_sample, input int unsigned c_sample);
    sample_pair_t pair;
    pair.phase_b = ADC_W'(b_sample);
    pair.phase_c = ADC_W'(c_sample);
    sample_backlog.push_back(pair);
  endtask

  // Waits until every queued request has been taken and every result has come back, then
  // goes on waiting so that the block is truly idle.
  task automatic drain();
    while (sample_backlog.size() != 0 || sample_held || expected_currents.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase_idx;
    int unsigned burst;
    int unsigned mid;
    int unsigned apc;
    int unsigned gain;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. At the reset register values: each phase at one rail with the other
    // at the opposite rail, both at zero (which lands exactly on the clip level), and
    // both at the midpoint. The window is still warming up, so zeros fill the rest.
    queue_pair(0, SAMPLE_MAX);
    queue_pair(SAMPLE_MAX, 0);
    queue_pair(0, 0);
    queue_pair(MID_RESET, MID_RESET);
    drain();

    // Midpoint at zero with full-scale samples drives the weighted value into the clip;
    // a whole window of those, with the largest factor and gain, gives the largest
    // average and power the outputs can carry.
    set_registers(0, 65535, 255);
    repeat (WIN_DEPTH) queue_pair(SAMPLE_MAX, SAMPLE_MAX);
    drain();

    // The opposite extreme: midpoint at full scale, zero factor and zero gain. This
    // request also retires the first clipped value in the ring.
    set_registers(SAMPLE_MAX, 0, 0);
    queue_pair(SAMPLE_MAX, SAMPLE_MAX);
    drain();

    // A write to the spare register index must leave all settings alone.
    write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom_range(0, 65535)));
    queue_pair(0, 0);
    drain();

    // Random part: several settings, among them both rails of the midpoint and the top of the
    // factor and gain, each with a burst of samples long enough to wrap the window a few times.
    for (phase_idx = 0; phase_idx < 8; phase_idx++) begin
      mid  = $urandom_range(0, SAMPLE_MAX);
      apc  = $urandom_range(0, 65535);
      gain = $urandom_range(0, 255);
      case (phase_idx)
        0: mid = 0;
        1: mid = SAMPLE_MAX;
        2: begin
          apc  = 65535;
          gain = 255;
        end
        3: begin
          mid = MID_RESET;
          apc = APC_RESET;
          gain = GAIN_RESET;
        end
        4: mid = $urandom_range(1900, 2200);
        default: ;
      endcase
      set_registers(mid, apc, gain);
      burst = $urandom_range(80, 100);
      repeat (burst) queue_pair(32'(draw_sample()), 32'(draw_sample()));
      drain();
    end

    if (mismatch_count == 0) begin
      $display("[phase_current_moving_average] OK");
    end else begin
      $display("[phase_current_moving_average] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, with every request meeting the longest
  // gaps and stalls on top of the block's own cycles.
  initial begin
    #15_000_000;
    $display("[phase_current_moving_average] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
hdl/pcma_pkg.sv
hdl/pcma_serial.sv
hdl/phase_current_moving_average.sv
test/phase_current_moving_average_tb.sv
